// ----- hw/rtl/fixed_block_free_list_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/fbfla_pkg.sv -----
// Shared types, codes and sizes of the fixed block free list allocator.
`default_nettype none
package fbfla_pkg;

    localparam int unsigned MAX_BLOCKS = 1024;
    localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W      = IDX_W + 1;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 24;
    localparam int unsigned BS_W    = 13;
    localparam int unsigned ALIGN_W = 3;
    localparam int unsigned PROD_W  = IDX_W + BS_W;

    localparam logic [CNT_W-1:0]  NO_BLOCK = CNT_W'(MAX_BLOCKS);
    localparam logic [SIZE_W-1:0] USED_MAX = '1;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;
    localparam logic [1:0] ST_NO_FIT    = 2'd3;

    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_POOL_SIZE  = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd2;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd3;

    localparam logic [ADDR_W-1:0]  RST_POOL_BASE  = '0;
    localparam logic [SIZE_W-1:0]  RST_POOL_SIZE  = 24'd65536;
    localparam logic [BS_W-1:0]    RST_BLOCK_SIZE = 13'd64;
    localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2 = 3'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] block_address;
    } t_in_beat;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic [SIZE_W-1:0] used_bytes;
    } t_out_beat;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [BS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [BS_W-1:0]   remainder;
    } t_div_rsp;

endpackage
`default_nettype wire

// ----- hw/rtl/fixed_block_free_list_allocator.sv -----
// Top level: fixed-size block pool with a LIFO free list kept in a link RAM.
// Allocate pops the list head from the link RAM; free runs a 32-step divide by block size.
// Clear: a divide by block size, then relinks the list in the link RAM block by block.
// One item at a time; input stall stays high from accept until its result is loaded.
// Reset loads the register defaults and runs a clear with no beat.
`default_nettype none
`include "fixed_block_free_list_allocator_defines.svh"
module fixed_block_free_list_allocator (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire fbfla_pkg::t_in_beat   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output fbfla_pkg::t_out_beat       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR_START,
        S_CLR_DIV,
        S_CLR_FILL,
        S_ALLOC_RD,
        S_ALLOC_WB,
        S_FREE_DIV,
        S_RESULT
    } t_state;

    localparam int unsigned IW = fbfla_pkg::IDX_W;
    localparam int unsigned CW = fbfla_pkg::CNT_W;

    t_state                            r_state;
    logic [fbfla_pkg::ADDR_W-1:0]      r_pool_base;
    logic [fbfla_pkg::SIZE_W-1:0]      r_pool_size;
    logic [fbfla_pkg::BS_W-1:0]        r_block_size;
    logic [fbfla_pkg::ALIGN_W-1:0]     r_align_log2;
    logic [CW-1:0]                     r_head;
    logic [CW-1:0]                     r_block_count;
    logic [CW-1:0]                     r_idx;
    logic [fbfla_pkg::SIZE_W-1:0]      r_used;
    logic [fbfla_pkg::ADDR_W-1:0]      r_first;
    logic [fbfla_pkg::PROD_W-1:0]      r_prod;
    logic                              r_clr_reply;
    fbfla_pkg::t_out_beat              r_res;
    logic                              r_out_valid;
    fbfla_pkg::t_out_beat              r_out;

    logic                              in_acc;
    fbfla_pkg::t_div_req               div_req;
    fbfla_pkg::t_div_rsp               div_rsp;
    logic                              ram_we;
    logic [IW-1:0]                     ram_waddr;
    logic [CW-1:0]                     ram_wdata;
    logic [CW-1:0]                     ram_rdata;

    logic [7:0]                        align_mask;
    logic [7:0]                        adj;
    logic                              clr_fits;
    logic [fbfla_pkg::ADDR_W-1:0]      free_off;
    logic                              free_pre_ok;
    logic                              free_ok;
    logic [CW-1:0]                     clr_n;
    logic [CW-1:0]                     idx_nxt;
    logic [fbfla_pkg::SIZE_W:0]        used_sum;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= fbfla_pkg::RST_POOL_BASE;
            r_pool_size  <= fbfla_pkg::RST_POOL_SIZE;
            r_block_size <= fbfla_pkg::RST_BLOCK_SIZE;
            r_align_log2 <= fbfla_pkg::RST_ALIGN_LOG2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbfla_pkg::REG_POOL_BASE:  r_pool_base  <= i_cfg_wdata;
                fbfla_pkg::REG_POOL_SIZE:  r_pool_size  <= i_cfg_wdata[fbfla_pkg::SIZE_W-1:0];
                fbfla_pkg::REG_BLOCK_SIZE: r_block_size <= i_cfg_wdata[fbfla_pkg::BS_W-1:0];
                fbfla_pkg::REG_ALIGN_LOG2: r_align_log2 <= i_cfg_wdata[fbfla_pkg::ALIGN_W-1:0];
            endcase
        end
    end

    always_comb begin
        align_mask  = (8'd1 << r_align_log2) - 8'd1;
        adj         = (8'd0 - r_pool_base[7:0]) & align_mask;
        clr_fits    = (r_block_size != '0) && (fbfla_pkg::SIZE_W'(adj) < r_pool_size);
        free_off    = i_in_data.block_address - r_first;
        free_pre_ok = (r_used != '0) && (r_block_size != '0) && (r_block_count != '0);
        free_ok     = (div_rsp.remainder == '0) &&
                      (div_rsp.quotient < fbfla_pkg::ADDR_W'(r_block_count));
        clr_n       = (div_rsp.quotient > fbfla_pkg::ADDR_W'(fbfla_pkg::MAX_BLOCKS)) ?
                      fbfla_pkg::NO_BLOCK : div_rsp.quotient[CW-1:0];
        idx_nxt     = r_idx + CW'(1);
        used_sum    = {1'b0, r_used} + (fbfla_pkg::SIZE_W + 1)'(r_block_size);
    end

    // divider is started from the clear entry or from an accepted free
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = fbfla_pkg::ADDR_W'(r_pool_size - fbfla_pkg::SIZE_W'(adj));
        div_req.divisor  = r_block_size;
        if (r_state == S_CLR_START) begin
            div_req.start = clr_fits;
        end else if (in_acc && (i_in_data.kind == fbfla_pkg::KIND_FREE)) begin
            div_req.start    = (i_in_data.block_address != '0) && free_pre_ok;
            div_req.dividend = free_off;
        end
    end

    always_comb begin
        if (r_state == S_CLR_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx[IW-1:0];
            ram_wdata = (idx_nxt == r_block_count) ? fbfla_pkg::NO_BLOCK : idx_nxt;
        end else begin
            ram_we    = (r_state == S_FREE_DIV) && div_rsp.done && free_ok;
            ram_waddr = div_rsp.quotient[IW-1:0];
            ram_wdata = r_head;
        end
    end

    fbfla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fbfla_ram #(
        .WIDTH (fbfla_pkg::CNT_W),
        .DEPTH (fbfla_pkg::MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR_START;
            r_clr_reply   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_head        <= fbfla_pkg::NO_BLOCK;
            r_block_count <= '0;
            r_used        <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res.result_address <= '0;
                        r_res.status         <= fbfla_pkg::ST_OK;
                        r_res.used_bytes     <= r_used;
                        unique case (i_in_data.kind)
                            fbfla_pkg::KIND_ALLOC: begin
                                if (r_head >= r_block_count) begin
                                    r_res.status <= fbfla_pkg::ST_EXHAUSTED;
                                    r_state      <= S_RESULT;
                                end else begin
                                    r_state <= S_ALLOC_RD;
                                end
                            end
                            fbfla_pkg::KIND_FREE: begin
                                // null free answers ok and changes nothing
                                if (i_in_data.block_address == '0) begin
                                    r_state <= S_RESULT;
                                end else if (!free_pre_ok) begin
                                    r_res.status <= fbfla_pkg::ST_REJECTED;
                                    r_state      <= S_RESULT;
                                end else begin
                                    r_state <= S_FREE_DIV;
                                end
                            end
                            fbfla_pkg::KIND_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLR_START;
                            end
                            fbfla_pkg::KIND_UNUSED: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_ALLOC_RD: begin
                    r_prod  <= r_head[IW-1:0] * r_block_size;
                    r_state <= S_ALLOC_WB;
                end
                S_ALLOC_WB: begin
                    r_head <= ram_rdata;
                    r_used <= used_sum[fbfla_pkg::SIZE_W] ? fbfla_pkg::USED_MAX :
                              used_sum[fbfla_pkg::SIZE_W-1:0];
                    r_res.used_bytes <= used_sum[fbfla_pkg::SIZE_W] ? fbfla_pkg::USED_MAX :
                                        used_sum[fbfla_pkg::SIZE_W-1:0];
                    r_res.result_address <= r_first + fbfla_pkg::ADDR_W'(r_prod);
                    r_state <= S_RESULT;
                end
                S_FREE_DIV: begin
                    if (div_rsp.done) begin
                        if (free_ok) begin
                            // push the block onto the list head
                            r_head <= div_rsp.quotient[CW-1:0];
                            r_used <= (r_used > fbfla_pkg::SIZE_W'(r_block_size)) ?
                                      r_used - fbfla_pkg::SIZE_W'(r_block_size) : '0;
                            r_res.used_bytes <= (r_used > fbfla_pkg::SIZE_W'(r_block_size)) ?
                                                r_used - fbfla_pkg::SIZE_W'(r_block_size) : '0;
                        end else begin
                            r_res.status <= fbfla_pkg::ST_REJECTED;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_CLR_START: begin
                    r_first              <= r_pool_base + fbfla_pkg::ADDR_W'(adj);
                    r_used               <= '0;
                    r_res.result_address <= '0;
                    r_res.used_bytes     <= '0;
                    if (clr_fits) begin
                        r_state <= S_CLR_DIV;
                    end else begin
                        r_block_count <= '0;
                        r_head        <= fbfla_pkg::NO_BLOCK;
                        r_res.status  <= fbfla_pkg::ST_NO_FIT;
                        r_state       <= r_clr_reply ? S_RESULT : S_IDLE;
                    end
                end
                S_CLR_DIV: begin
                    if (div_rsp.done) begin
                        r_block_count <= clr_n;
                        r_idx         <= '0;
                        if (clr_n == '0) begin
                            r_head       <= fbfla_pkg::NO_BLOCK;
                            r_res.status <= fbfla_pkg::ST_NO_FIT;
                            r_state      <= r_clr_reply ? S_RESULT : S_IDLE;
                        end else begin
                            r_head       <= '0;
                            r_res.status <= fbfla_pkg::ST_OK;
                            r_state      <= S_CLR_FILL;
                        end
                    end
                end
                S_CLR_FILL: begin
                    // link block i to i+1, last one to the end marker
                    r_idx <= idx_nxt;
                    if (idx_nxt == r_block_count) begin
                        r_state <= r_clr_reply ? S_RESULT : S_IDLE;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMP(a_head_in_pool, i_clk, i_rst_n, (r_state == S_IDLE) && (r_head != fbfla_pkg::NO_BLOCK), r_head < r_block_count)
    `ASSERT_IMP(a_div_done_expected, i_clk, i_rst_n, div_rsp.done, (r_state == S_CLR_DIV) || (r_state == S_FREE_DIV))
    `ASSERT_NEXT(a_result_loads, i_clk, i_rst_n, (r_state == S_RESULT) && (!r_out_valid || !i_out_stall), o_out_valid && (r_state == S_IDLE))

endmodule
`default_nettype wire

// ----- hw/rtl/fbfla_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fbfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/fbfla_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by clear and free.
`default_nettype none
module fbfla_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fbfla_pkg::t_div_req i_req,
    output fbfla_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned CW = $clog2(fbfla_pkg::ADDR_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [fbfla_pkg::ADDR_W-1:0]  r_quo;
    logic [fbfla_pkg::BS_W-1:0]    r_rem;
    logic [fbfla_pkg::BS_W-1:0]    r_dvs;

    logic [fbfla_pkg::BS_W:0]      rem_sh;
    logic [fbfla_pkg::BS_W+1:0]    diff;
    logic                          ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[fbfla_pkg::ADDR_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = !diff[fbfla_pkg::BS_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // one trial subtract, shift the quotient bit in
                r_rem <= ge ? diff[fbfla_pkg::BS_W-1:0] : rem_sh[fbfla_pkg::BS_W-1:0];
                r_quo <= {r_quo[fbfla_pkg::ADDR_W-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(fbfla_pkg::ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire
